FILE: design/ptd_pkg.sv
package ptd_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 16;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// command codes on the input channel
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;

	// event codes on the output channel
	localparam logic [2:0] EV_ADDED    = 3'd0;
	localparam logic [2:0] EV_REJECT   = 3'd1;
	localparam logic [2:0] EV_DISPATCH = 3'd2;
	localparam logic [2:0] EV_DONE     = 3'd3;
	localparam logic [2:0] EV_FAULT    = 3'd4;
	localparam logic [2:0] EV_IGNORED  = 3'd5;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ADD,
		OP_IGNORE,
		OP_WALK_INIT,
		OP_RPT_PASS,
		OP_RPT_FAULT,
		OP_STEP,
		OP_DISPATCH,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_DECODE = 3'b010,
		S_WALK   = 3'b100
	} state_t;

	typedef struct packed {
		logic in_ready;
		op_t  op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] cmd;
		logic       awaiting;
		logic       walk_end;
		logic       cd_zero;
		logic       oob;
		logic       out_free;
	} dp_status_t;

endpackage

FILE: design/ptd_ifs.sv
interface ptd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  task_ident;
	logic [15:0] period_ticks;
	logic [15:0] start_offset;
	logic [15:0] min_time;
	logic [15:0] max_time;
	logic [15:0] measured_time;

	modport source(output valid, cmd, task_ident, period_ticks, start_offset,
		min_time, max_time, measured_time, input ready);
	modport sink(input valid, cmd, task_ident, period_ticks, start_offset,
		min_time, max_time, measured_time, output ready);
endinterface

interface ptd_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [3:0]  task_index;
	logic [7:0]  out_ident;
	logic [15:0] worst_seen;
	logic [4:0]  entries_used;

	modport source(output valid, event_res, task_index, out_ident, worst_seen,
		entries_used, input ready);
	modport sink(input valid, event_res, task_index, out_ident, worst_seen,
		entries_used, output ready);
endinterface

FILE: design/periodic_task_dispatcher.sv
// Add, faulting report and ignored commands register their result from the decode state after accept.
// A tick walks the table, stepping entries until a due task or the end of the table, and then
// registers its result; an in-bounds report resumes the walk the same way.
// One transaction at a time: the next is accepted once the result is registered and the block is
// back in idle; a full output register that is not drained holds off the result.
// Reset (arst_n, async, active low): empty table, no report pending, output empty.
module periodic_task_dispatcher (
	input  logic     clk,
	input  logic     arst_n,
	ptd_req_if.sink  req,
	ptd_evt_if.source evt
);

	// Controller sequences each transaction: decode, then the table walk.
	// The datapath holds the latched request, the task table and the
	// output register; a new request is taken while a result waits there.
	ptd_pkg::ctrl_cmd_t  ctrl;
	ptd_pkg::dp_status_t status;

	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Table read port is the walk position; writes go to the append slot on add
	// or back to the walk position on step, dispatch and report.
	ptd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.evt    (evt),
		.ctrl   (ctrl),
		.status (status)
	);

endmodule

FILE: design/ptd_ctrl.sv
module ptd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptd_pkg::dp_status_t    status,
	output ptd_pkg::ctrl_cmd_t     ctrl
);

	ptd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctrl.in_ready = 1'b0;
		ctrl.op       = ptd_pkg::OP_NONE;
		unique case (state_q)
			ptd_pkg::S_IDLE: begin
				ctrl.in_ready = 1'b1;
				if (status.in_valid) begin
					state_d = ptd_pkg::S_DECODE;
				end
			end
			ptd_pkg::S_DECODE: begin
				priority if (status.cmd == ptd_pkg::CMD_ADD && !status.awaiting) begin
					if (status.out_free) begin
						ctrl.op = ptd_pkg::OP_ADD;
						state_d = ptd_pkg::S_IDLE;
					end
				end else if (status.cmd == ptd_pkg::CMD_TICK && !status.awaiting) begin
					ctrl.op = ptd_pkg::OP_WALK_INIT;
					state_d = ptd_pkg::S_WALK;
				end else if (status.cmd == ptd_pkg::CMD_REPORT && status.awaiting) begin
					if (!status.oob) begin
						ctrl.op = ptd_pkg::OP_RPT_PASS;
						state_d = ptd_pkg::S_WALK;
					end else if (status.out_free) begin
						ctrl.op = ptd_pkg::OP_RPT_FAULT;
						state_d = ptd_pkg::S_IDLE;
					end
				end else begin
					if (status.out_free) begin
						ctrl.op = ptd_pkg::OP_IGNORE;
						state_d = ptd_pkg::S_IDLE;
					end
				end
			end
			ptd_pkg::S_WALK: begin
				priority if (status.walk_end) begin
					if (status.out_free) begin
						ctrl.op = ptd_pkg::OP_DONE;
						state_d = ptd_pkg::S_IDLE;
					end
				end else if (!status.cd_zero) begin
					ctrl.op = ptd_pkg::OP_STEP;
				end else begin
					if (status.out_free) begin
						ctrl.op = ptd_pkg::OP_DISPATCH;
						state_d = ptd_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = ptd_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/ptd_dp.sv
module ptd_dp (
	input  logic                clk,
	input  logic                arst_n,
	ptd_req_if.sink             req,
	ptd_evt_if.source           evt,
	input  ptd_pkg::ctrl_cmd_t  ctrl,
	output ptd_pkg::dp_status_t status
);

	// latched request
	logic [1:0]     req_cmd_q;
	logic [7:0]     req_ident_q;
	logic [15:0]    req_period_q;
	logic [15:0]    req_offset_q;
	ptd_pkg::time_t req_min_q;
	ptd_pkg::time_t req_max_q;
	ptd_pkg::time_t req_meas_q;

	// task table
	logic [7:0]     tbl_ident_q  [ptd_pkg::MAX_TASKS];
	logic [15:0]    tbl_period_q [ptd_pkg::MAX_TASKS];
	logic [15:0]    tbl_cd_q     [ptd_pkg::MAX_TASKS];
	ptd_pkg::time_t tbl_min_q    [ptd_pkg::MAX_TASKS];
	ptd_pkg::time_t tbl_max_q    [ptd_pkg::MAX_TASKS];
	ptd_pkg::time_t tbl_worst_q  [ptd_pkg::MAX_TASKS];

	ptd_pkg::cnt_t  count_q;
	ptd_pkg::cnt_t  walk_q;
	logic           awaiting_q;

	// output register
	logic           evt_valid_q;
	logic [2:0]     evt_res_q;
	logic [3:0]     evt_idx_q;
	logic [7:0]     evt_ident_q;
	logic [15:0]    evt_worst_q;
	logic [4:0]     evt_used_q;

	ptd_pkg::idx_t  pos;
	ptd_pkg::idx_t  wr_slot;
	ptd_pkg::time_t new_worst;
	logic           oob;
	logic           reject;
	logic           out_free;
	logic           req_fire;

	logic           emit;
	logic [2:0]     em_res;
	logic [3:0]     em_idx;
	logic [7:0]     em_ident;
	logic [15:0]    em_worst;
	logic [4:0]     em_used;

	assign req.ready = ctrl.in_ready;
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !evt_valid_q || evt.ready;

	assign pos       = walk_q[ptd_pkg::IDX_W-1:0];
	assign wr_slot   = count_q[ptd_pkg::IDX_W-1:0];
	assign oob       = (req_meas_q < tbl_min_q[pos]) || (req_meas_q > tbl_max_q[pos]);
	assign new_worst = (tbl_worst_q[pos] < req_meas_q) ? req_meas_q : tbl_worst_q[pos];
	assign reject    = (req_period_q == 16'd0) || (req_ident_q == 8'd0) ||
		(count_q >= ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS));

	assign status.in_valid = req.valid;
	assign status.cmd      = req_cmd_q;
	assign status.awaiting = awaiting_q;
	assign status.walk_end = (walk_q >= count_q);
	assign status.cd_zero  = (tbl_cd_q[pos] == 16'd0);
	assign status.oob      = oob;
	assign status.out_free = out_free;

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_cmd_q    <= req.cmd;
			req_ident_q  <= req.task_ident;
			req_period_q <= req.period_ticks;
			req_offset_q <= req.start_offset;
			req_min_q    <= ptd_pkg::TIME_BITS'(req.min_time);
			req_max_q    <= ptd_pkg::TIME_BITS'(req.max_time);
			req_meas_q   <= ptd_pkg::TIME_BITS'(req.measured_time);
		end
	end

	// table writes
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ptd_pkg::OP_ADD: begin
				if (!reject) begin
					tbl_ident_q[wr_slot]  <= req_ident_q;
					tbl_period_q[wr_slot] <= req_period_q;
					tbl_cd_q[wr_slot]     <= req_offset_q;
					tbl_min_q[wr_slot]    <= req_min_q;
					tbl_max_q[wr_slot]    <= req_max_q;
					tbl_worst_q[wr_slot]  <= '0;
				end
			end
			ptd_pkg::OP_RPT_PASS, ptd_pkg::OP_RPT_FAULT: begin
				tbl_worst_q[pos] <= new_worst;
			end
			ptd_pkg::OP_STEP: begin
				tbl_cd_q[pos] <= tbl_cd_q[pos] - 16'd1;
			end
			ptd_pkg::OP_DISPATCH: begin
				tbl_cd_q[pos] <= tbl_period_q[pos] - 16'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			walk_q     <= '0;
			awaiting_q <= 1'b0;
		end else begin
			unique case (ctrl.op)
				ptd_pkg::OP_ADD: begin
					if (!reject) begin
						count_q <= count_q + 1'b1;
					end
				end
				ptd_pkg::OP_WALK_INIT, ptd_pkg::OP_DONE: begin
					walk_q <= '0;
				end
				ptd_pkg::OP_RPT_PASS: begin
					awaiting_q <= 1'b0;
					walk_q     <= walk_q + 1'b1;
				end
				ptd_pkg::OP_RPT_FAULT: begin
					awaiting_q <= 1'b0;
					walk_q     <= '0;
				end
				ptd_pkg::OP_STEP: begin
					walk_q <= walk_q + 1'b1;
				end
				ptd_pkg::OP_DISPATCH: begin
					awaiting_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result selection
	always_comb begin
		emit     = 1'b0;
		em_res   = ptd_pkg::EV_IGNORED;
		em_idx   = '0;
		em_ident = '0;
		em_worst = '0;
		em_used  = 5'(count_q);
		unique case (ctrl.op)
			ptd_pkg::OP_ADD: begin
				emit     = 1'b1;
				em_ident = req_ident_q;
				if (reject) begin
					em_res = ptd_pkg::EV_REJECT;
				end else begin
					em_res  = ptd_pkg::EV_ADDED;
					em_idx  = 4'(count_q);
					em_used = 5'(count_q + 1'b1);
				end
			end
			ptd_pkg::OP_IGNORE: begin
				emit = 1'b1;
			end
			ptd_pkg::OP_RPT_FAULT: begin
				emit     = 1'b1;
				em_res   = ptd_pkg::EV_FAULT;
				em_idx   = 4'(pos);
				em_ident = tbl_ident_q[pos];
				em_worst = 16'(new_worst);
			end
			ptd_pkg::OP_DISPATCH: begin
				emit     = 1'b1;
				em_res   = ptd_pkg::EV_DISPATCH;
				em_idx   = 4'(pos);
				em_ident = tbl_ident_q[pos];
				em_worst = 16'(tbl_worst_q[pos]);
			end
			ptd_pkg::OP_DONE: begin
				emit   = 1'b1;
				em_res = ptd_pkg::EV_DONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (emit) begin
			evt_valid_q <= 1'b1;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			evt_res_q   <= em_res;
			evt_idx_q   <= em_idx;
			evt_ident_q <= em_ident;
			evt_worst_q <= em_worst;
			evt_used_q  <= em_used;
		end
	end

	assign evt.valid        = evt_valid_q;
	assign evt.event_res    = evt_res_q;
	assign evt.task_index   = evt_idx_q;
	assign evt.out_ident    = evt_ident_q;
	assign evt.worst_seen   = evt_worst_q;
	assign evt.entries_used = evt_used_q;

endmodule

FILE: tb/sv/tb_periodic_task_dispatcher.sv
module tb_periodic_task_dispatcher;
	import ptd_pkg::*;

	// cmd code 3 is unused by the block and must come back as ignored
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 780;
	localparam int PERIOD       = 8;

	// one request transaction as the driver sees it
	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  ident;
		logic [15:0] period;
		logic [15:0] offset;
		logic [15:0] tmin;
		logic [15:0] tmax;
		logic [15:0] meas;
	} sched_req_t;

	// one event transaction, field for field as on the output channel
	typedef struct {
		logic [2:0]  ev;
		idx_t        slot;
		logic [7:0]  ident;
		logic [15:0] worst;
		cnt_t        used;
	} sched_evt_t;

	logic clk = 1'b0;
	logic arst_n;

	ptd_req_if req_ch ();
	ptd_evt_if evt_ch ();

	periodic_task_dispatcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.evt    (evt_ch)
	);

	always #(PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Scheduler shadow: task table, walk position and the report flag.
	// Slots at or above tbl_count are never read.
	// ------------------------------------------------------------------
	logic [7:0]  tbl_ident [MAX_TASKS];
	logic [15:0] tbl_period[MAX_TASKS];
	logic [15:0] tbl_cd    [MAX_TASKS];
	time_t       tbl_min   [MAX_TASKS];
	time_t       tbl_max   [MAX_TASKS];
	time_t       tbl_worst [MAX_TASKS] = '{default: '0};
	int          tbl_count = 0;
	int          tbl_pos   = 0;
	bit          tbl_wait  = 1'b0;

	sched_req_t pending_reqs[$];     // stimulus not yet presented
	sched_evt_t expected_events[$];  // predicted events, oldest first

	int n_errors   = 0;
	int n_accepted = 0;
	int ev_tally[8] = '{default: 0};

	// when set, neither side inserts idle cycles
	bit steady = 1'b0;

	function automatic sched_evt_t make_evt(logic [2:0] ev, int slot, logic [7:0] ident,
			logic [15:0] worst);
		sched_evt_t e;
		e.ev    = ev;
		e.slot  = idx_t'(slot);
		e.ident = ident;
		e.worst = worst;
		e.used  = cnt_t'(tbl_count);
		return e;
	endfunction

	// Walk from tbl_pos: count down idle entries, stop at the first due one.
	function automatic sched_evt_t resume_walk();
		int i;
		for (i = tbl_pos; i < tbl_count; i++) begin
			if (tbl_cd[i] != 0) begin
				tbl_cd[i] = tbl_cd[i] - 16'd1;
			end else begin
				tbl_cd[i] = tbl_period[i] - 16'd1;
				tbl_wait  = 1'b1;
				tbl_pos   = i;
				return make_evt(EV_DISPATCH, i, tbl_ident[i], tbl_worst[i]);
			end
		end
		tbl_pos = 0;
		return make_evt(EV_DONE, 0, 8'd0, 16'd0);
	endfunction

	// Next event for one accepted request; updates the shadow table.
	function automatic sched_evt_t schedule_step(sched_req_t r);
		int    s;
		time_t m;
		m = time_t'(r.meas);
		if (r.cmd == CMD_ADD && !tbl_wait) begin
			if (r.period == 0 || r.ident == 0 || tbl_count >= MAX_TASKS)
				return make_evt(EV_REJECT, 0, r.ident, 16'd0);
			s = tbl_count;
			tbl_ident[s]  = r.ident;
			tbl_period[s] = r.period;
			tbl_cd[s]     = r.offset;
			tbl_min[s]    = time_t'(r.tmin);
			tbl_max[s]    = time_t'(r.tmax);
			tbl_worst[s]  = '0;
			tbl_count     = s + 1;
			return make_evt(EV_ADDED, s, r.ident, 16'd0);
		end
		if (r.cmd == CMD_TICK && !tbl_wait) begin
			tbl_pos = 0;
			return resume_walk();
		end
		if (r.cmd == CMD_REPORT && tbl_wait) begin
			s = tbl_pos;
			tbl_wait = 1'b0;
			// worst time tracks out-of-bounds values too
			if (tbl_worst[s] < m)
				tbl_worst[s] = m;
			if (m < tbl_min[s] || m > tbl_max[s]) begin
				tbl_pos = 0;
				return make_evt(EV_FAULT, s, tbl_ident[s], tbl_worst[s]);
			end
			tbl_pos = s + 1;
			return resume_walk();
		end
		return make_evt(EV_IGNORED, 0, 8'd0, 16'd0);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic sched_req_t mk_req(logic [1:0] c, logic [7:0] id, logic [15:0] per,
			logic [15:0] off, logic [15:0] lo, logic [15:0] hi, logic [15:0] meas);
		sched_req_t r;
		r.cmd    = c;
		r.ident  = id;
		r.period = per;
		r.offset = off;
		r.tmin   = lo;
		r.tmax   = hi;
		r.meas   = meas;
		return r;
	endfunction

	// mostly short pauses, now and then a long one
	function automatic int pause_len();
		if ($urandom_range(0, 9) < 9)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random add: small periods and offsets dominate so tasks actually come due.
	function automatic sched_req_t rand_add();
		logic [7:0]  id;
		logic [15:0] per, off, lo, hi;
		int          r;
		id = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		r = $urandom_range(0, 19);
		if (r == 0)
			per = 16'd0;
		else if (r < 3)
			per = 16'($urandom());
		else if (r < 8)
			per = 16'($urandom_range(5, 20));
		else
			per = 16'($urandom_range(1, 4));
		off = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
		r = $urandom_range(0, 19);
		if (r < 2) begin
			// fully random bounds, min above max included
			lo = 16'($urandom());
			hi = 16'($urandom());
		end else if (r == 2) begin
			lo = 16'd0;
			hi = 16'hFFFF;
		end else begin
			lo = 16'($urandom_range(0, 100));
			hi = lo + 16'($urandom_range(0, 200));
		end
		return mk_req(CMD_ADD, id, per, off, lo, hi, 16'($urandom()));
	endfunction

	// Run time for the dispatched task: mostly in bounds, some outside.
	function automatic logic [15:0] pick_runtime();
		int lo, hi, r;
		lo = tbl_min[tbl_pos];
		hi = tbl_max[tbl_pos];
		r  = $urandom_range(0, 19);
		if (lo > hi || r == 0)
			return 16'($urandom());
		if (r < 3 && lo > 0)
			return 16'($urandom_range(0, lo - 1));
		if (r < 5 && hi < 16'hFFFF)
			return 16'($urandom_range(hi + 1, 16'hFFFF));
		return 16'($urandom_range(lo, hi));
	endfunction

	// arbitrary transactions in any state; those that do not fit the state come back ignored
	task automatic push_noise();
		int n;
		n = $urandom_range(1, 3);
		repeat (n)
			pending_reqs.push_back(mk_req(2'($urandom_range(0, 3)), 8'($urandom()),
				16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
				16'($urandom())));
	endtask

	// block until the sender is empty and every predicted event has come back;
	// sampled mid-cycle so the clocked blocks have settled
	task automatic wait_settled();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_events.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Request driver: presents queued transactions, random gaps between.
	// The prediction runs at the edge a transaction is accepted.
	// ------------------------------------------------------------------
	sched_req_t drv_item;
	sched_evt_t drv_pred;
	int         drv_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid         <= 1'b0;
			req_ch.cmd           <= CMD_ADD;
			req_ch.task_ident    <= '0;
			req_ch.period_ticks  <= '0;
			req_ch.start_offset  <= '0;
			req_ch.min_time      <= '0;
			req_ch.max_time      <= '0;
			req_ch.measured_time <= '0;
			drv_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				drv_pred = schedule_step(drv_item);
				expected_events.push_back(drv_pred);
				ev_tally[drv_pred.ev]++;
				n_accepted++;
			end
			// hold the payload while the block stalls us
			if (!(req_ch.valid && !req_ch.ready)) begin
				if (drv_gap > 0) begin
					drv_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					drv_item = pending_reqs.pop_front();
					req_ch.valid         <= 1'b1;
					req_ch.cmd           <= drv_item.cmd;
					req_ch.task_ident    <= drv_item.ident;
					req_ch.period_ticks  <= drv_item.period;
					req_ch.start_offset  <= drv_item.offset;
					req_ch.min_time      <= drv_item.tmin;
					req_ch.max_time      <= drv_item.tmax;
					req_ch.measured_time <= drv_item.meas;
					drv_gap = (steady || $urandom_range(0, 2) != 0) ? 0 : pause_len();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Event monitor: random back-pressure, in-order compare per field.
	// ------------------------------------------------------------------
	sched_evt_t want;
	int         stall_left;

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (evt_ch.valid && evt_ch.ready) begin
				if (expected_events.size() == 0) begin
					$display("%0t: event with nothing expected: expected none, actual event %0d",
						$time, evt_ch.event_res);
					n_errors++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_res", 32'(want.ev), 32'(evt_ch.event_res));
					check_field("task_index", 32'(want.slot), 32'(evt_ch.task_index));
					check_field("out_ident", 32'(want.ident), 32'(evt_ch.out_ident));
					check_field("worst_seen", 32'(want.worst), 32'(evt_ch.worst_seen));
					check_field("entries_used", 32'(want.used), 32'(evt_ch.entries_used));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				evt_ch.ready <= 1'b0;
			end else begin
				evt_ch.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = pause_len();
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int sent;
		int r;
		int n;

		// channel signals are set by the driver and monitor while in reset
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// --- directed: corner cases on a tiny three-task table ---
		// report with nothing dispatched, unused code, tick on empty table
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'hFFFF));
		pending_reqs.push_back(mk_req(CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		// rejected adds: identity zero, period zero
		pending_reqs.push_back(mk_req(CMD_ADD, 8'h00, 16'd5, 0, 0, 16'd10, 0));
		pending_reqs.push_back(mk_req(CMD_ADD, 8'h33, 16'd0, 0, 0, 16'd10, 0));
		// slot 0 due every tick, slot 1 never due, slot 2 every other tick
		pending_reqs.push_back(mk_req(CMD_ADD, 8'hFF, 16'd1, 0, 0, 16'hFFFF, 0));
		pending_reqs.push_back(mk_req(CMD_ADD, 8'h01, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 0));
		pending_reqs.push_back(mk_req(CMD_ADD, 8'h5A, 16'd2, 16'd1, 16'd10, 16'd20, 0));
		// dispatch slot 0, then add / tick / unused while a report is owed
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_ADD, 8'h77, 16'd3, 0, 0, 16'd5, 0));
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_UNUSED, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'hFFFF));
		// slot 2 comes due and reports below its minimum
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'd5));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'd9));
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'd0));
		// slot 2 reports above its maximum
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'h8000));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'd21));
		// slot 2 is not due again, so the tick completes and a report at its maximum is ignored
		pending_reqs.push_back(mk_req(CMD_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'd3));
		pending_reqs.push_back(mk_req(CMD_REPORT, 0, 0, 0, 0, 0, 16'd20));
		wait_settled();

		// --- random: ticks answered by reports, adds until full, some noise ---
		// Each step looks at the settled shadow state, so a dispatch is always
		// followed by a report for the right task.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (tbl_wait) begin
				if (r < 5) begin
					push_noise();
				end else begin
					pending_reqs.push_back(mk_req(CMD_REPORT, 8'($urandom()), 16'($urandom()),
						16'($urandom()), 16'($urandom()), 16'($urandom()), pick_runtime()));
					sent++;
				end
			end else if (r < 12) begin
				// adds never leave a report owed, so a burst of them is safe
				n = $urandom_range(1, 3);
				repeat (n)
					pending_reqs.push_back(rand_add());
				sent += n;
			end else if (r < 17) begin
				push_noise();
			end else begin
				pending_reqs.push_back(mk_req(CMD_TICK, 8'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())));
				sent++;
			end
			wait_settled();
		end

		// drained; allow a full walk's worth of cycles for anything stray
		steady = 1'b0;
		repeat (MAX_TASKS + 8) @(posedge clk);

		$display("run covered %0d transactions with %0d tasks in the table:", n_accepted,
			tbl_count);
		$display("  %0d added, %0d rejected, %0d dispatched, %0d faults, %0d ticks done, %0d ignored",
			ev_tally[EV_ADDED], ev_tally[EV_REJECT], ev_tally[EV_DISPATCH],
			ev_tally[EV_FAULT], ev_tally[EV_DONE], ev_tally[EV_IGNORED]);
		if (n_errors == 0 && expected_events.size() == 0) begin
			$display("[periodic_task_dispatcher] OK");
		end else begin
			$display("%0d failures, %0d events still expected", n_errors,
				expected_events.size());
			$display("[periodic_task_dispatcher] ERROR");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#8000000;
		$display("timeout with %0d events still expected", expected_events.size());
		$display("[periodic_task_dispatcher] ERROR");
		$finish;
	end

endmodule
